// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the design files.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SLD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sld same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sld next-cycle check failed");

`endif

// ----- design/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg
// Types and constants of the string literal UTF-8 decoder.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 16;
  localparam int CP_W     = 21;
  localparam int PEND_W   = 2;

  // Item kinds on the input channel. The fourth code carries no meaning.
  typedef enum logic [ACTION_W-1:0] {
    ACT_BODY  = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2
  } sld_action_t;

  localparam logic [COL_W-1:0] COL_MAX = '1;

  // Characters that the escape logic looks at or produces.
  localparam logic [CP_W-1:0] CH_BACKSLASH = 21'h00005C;
  localparam logic [CP_W-1:0] CH_N         = 21'h00006E;
  localparam logic [CP_W-1:0] CH_R         = 21'h000072;
  localparam logic [CP_W-1:0] CH_E         = 21'h000065;
  localparam logic [CP_W-1:0] CP_LF        = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR        = 21'h00000D;
  localparam logic [CP_W-1:0] CP_ESC       = 21'h00001B;

endpackage

// ----- design/sld_in_if.sv -----
// ----------------------------------------------------------------------------
// sld_in_if
// Input word channel: one raw byte of a string literal with its item kind.
// ----------------------------------------------------------------------------
interface sld_in_if;
  logic                           valid;
  logic                           ready;
  logic [sld_pkg::ACTION_W-1:0]   action;
  logic [sld_pkg::BYTE_W-1:0]     data_byte;
  logic [sld_pkg::COL_W-1:0]      start_column;

  modport source (output valid, output action, output data_byte, output start_column,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input start_column,
                  output ready);
endinterface

// ----- design/sld_out_if.sv -----
// ----------------------------------------------------------------------------
// sld_out_if
// Result word channel: one decoded character with its column.
// ----------------------------------------------------------------------------
interface sld_out_if;
  logic                        valid;
  logic                        ready;
  logic [sld_pkg::CP_W-1:0]    code_point;
  logic [sld_pkg::COL_W-1:0]   column;
  logic                        bad_lead;

  modport source (output valid, output code_point, output column, output bad_lead,
                  input ready);
  modport sink   (input valid, input code_point, input column, input bad_lead,
                  output ready);
endinterface

// ----- design/string_literal_utf8_decoder.sv -----
// ----------------------------------------------------------------------------
// string_literal_utf8_decoder
// A result word is registered and appears in the cycle after the byte that completes it.
// Throughput: one input word per cycle; the output register is refilled in
// the same cycle that its word is taken, so a stalled sink is the only limit.
// Reset: synchronous, active low; clears the decode state, the column base
// and the output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module string_literal_utf8_decoder (
  input  logic       clk,
  input  logic       rst_n,
  sld_in_if.sink     in_chan,
  sld_out_if.source  out_chan
);
  import sld_pkg::*;

  // Decode state. All of it is updated in the cycle a word is accepted.
  logic [PEND_W-1:0] pend_r, pend_nxt;   // continuation bytes still expected
  logic [CP_W-1:0]   acc_r,  acc_nxt;    // code point under assembly
  logic              esc_r,  esc_nxt;    // a backslash came just before
  logic [COL_W-1:0]  idx_r,  idx_nxt;    // characters seen in this literal
  logic [COL_W-1:0]  base_r, base_nxt;   // start column of this literal

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   out_cp_r,    out_cp_nxt;
  logic [COL_W-1:0]  out_col_r,   out_col_nxt;
  logic              out_bad_r,   out_bad_nxt;

  logic              in_fire;
  logic              out_fire;
  logic [COL_W:0]    col_sum;
  logic [COL_W-1:0]  cur_col;
  logic [COL_W-1:0]  idx_bump;
  logic [CP_W-1:0]   acc_shift;
  logic [BYTE_W-1:0] b;
  logic              have_char;
  logic [CP_W-1:0]   char_cp;
  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  logic              emit_bad;

  // The output slot is free when empty or being drained this cycle, so a new
  // word is taken every cycle as long as the sink keeps up.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_valid_r && out_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.code_point = out_cp_r;
  assign out_chan.column     = out_col_r;
  assign out_chan.bad_lead   = out_bad_r;

  assign b = in_chan.data_byte;

  // Column of the character being emitted now, saturating at the top.
  assign col_sum = {1'b0, base_r} + {1'b0, idx_r};
  assign cur_col = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];

  // The character index sticks at its maximum.
  assign idx_bump = (idx_r == COL_MAX) ? idx_r : idx_r + 1'b1;

  // A continuation byte shifts in six payload bits; the accumulator keeps
  // its low 21 bits.
  assign acc_shift = {acc_r[CP_W-7:0], b[5:0]};

  always_comb begin
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    esc_nxt   = esc_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    have_char = 1'b0;
    char_cp   = '0;
    emit      = 1'b0;
    emit_cp   = '0;
    emit_bad  = 1'b0;

    if (in_fire) begin
      case (in_chan.action)
        ACT_OPEN: begin
          // A new literal starts: clear everything and latch its column.
          pend_nxt = '0;
          acc_nxt  = '0;
          esc_nxt  = 1'b0;
          idx_nxt  = '0;
          base_nxt = in_chan.start_column;
        end
        ACT_CLOSE: begin
          // Drop a partial character and a dangling backslash; keep columns.
          pend_nxt = '0;
          acc_nxt  = '0;
          esc_nxt  = 1'b0;
        end
        ACT_BODY: begin
          if (pend_r != '0) begin
            // Continuation bytes are taken as they come, unchecked.
            pend_nxt = pend_r - 1'b1;
            if (pend_r == PEND_W'(1)) begin
              have_char = 1'b1;
              char_cp   = acc_shift;
              acc_nxt   = '0;
            end else begin
              acc_nxt = acc_shift;
            end
          end else if (b[7] == 1'b0) begin
            have_char = 1'b1;
            char_cp   = CP_W'(b[6:0]);
          end else if (b[7:5] == 3'b110) begin
            acc_nxt  = CP_W'(b[4:0]);
            pend_nxt = PEND_W'(1);
          end else if (b[7:4] == 4'b1110) begin
            acc_nxt  = CP_W'(b[3:0]);
            pend_nxt = PEND_W'(2);
          end else if (b[7:3] == 5'b11110) begin
            acc_nxt  = CP_W'(b[2:0]);
            pend_nxt = PEND_W'(3);
          end else begin
            // A stray continuation byte or an over-long lead: report it at
            // the current column and start over.
            acc_nxt  = '0;
            pend_nxt = '0;
            esc_nxt  = 1'b0;
            emit     = 1'b1;
            emit_bad = 1'b1;
            idx_nxt  = idx_bump;
          end

          // A completed character goes through the escape logic.
          if (have_char) begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              emit    = 1'b1;
              if (char_cp == CH_N) begin
                emit_cp = CP_LF;
              end else if (char_cp == CH_R) begin
                emit_cp = CP_CR;
              end else if (char_cp == CH_E) begin
                emit_cp = CP_ESC;
              end else begin
                emit_cp = char_cp;
              end
              idx_nxt = idx_bump;
            end else if (char_cp == CH_BACKSLASH) begin
              // The backslash itself takes a column but gives no word.
              esc_nxt = 1'b1;
              idx_nxt = idx_bump;
            end else begin
              emit    = 1'b1;
              emit_cp = char_cp;
              idx_nxt = idx_bump;
            end
          end
        end
        default: begin
          // The unused item kind changes nothing.
        end
      endcase
    end
  end

  // Output register: loaded on every accepted word, holding its contents
  // while the sink stalls.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_col_nxt   = out_col_r;
    out_bad_nxt   = out_bad_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = emit;
      out_cp_nxt    = emit_cp;
      out_col_nxt   = cur_col;
      out_bad_nxt   = emit_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      acc_r       <= '0;
      esc_r       <= 1'b0;
      idx_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      esc_r       <= esc_nxt;
      idx_r       <= idx_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r  <= out_cp_nxt;
    out_col_r <= out_col_nxt;
    out_bad_r <= out_bad_nxt;
  end

  // An opening word leaves a clean decoder at index zero.
  `SLD_ASSERT_NEXT(a_open_clears, in_fire && in_chan.action == ACT_OPEN, pend_r == '0 && !esc_r && idx_r == '0 && !out_valid_r)
  // A waiting word never shows a column before the literal's start.
  `SLD_ASSERT_IMPL(a_col_not_below_base, out_valid_r, out_col_r >= base_r)
  // An empty output slot never blocks the input side.
  `SLD_ASSERT_IMPL(a_ready_when_empty, !out_valid_r, in_chan.ready)
  // An error word always carries code point zero.
  `SLD_ASSERT_IMPL(a_bad_zero_cp, out_valid_r && out_bad_r, out_cp_r == '0)

endmodule

// ----- dv/string_literal_utf8_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// string_literal_utf8_decoder_tb
// Self-checking bench for the string literal UTF-8 decoder. A queue of byte
// words feeds a clocked driver, and every accepted word goes through a local
// model of the decoder that queues the character words it should produce. A
// clocked monitor compares each returned word with the oldest queued one.
// ----------------------------------------------------------------------------
module string_literal_utf8_decoder_tb;
  import sld_pkg::*;

  // The fourth action code has no meaning; the decoder must ignore it.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Cycles without any word moving on either channel before the run is given up.
  localparam int STALL_LIMIT = 3000;
  // Tail wait after the last drain, before the final verdict.
  localparam int TAIL_CYCLES = 4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic [COL_W-1:0]    start_column;
  } byte_word_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [COL_W-1:0] column;
    logic             bad_lead;
  } char_word_t;

  logic clk = 1'b0;
  logic rst_n;

  sld_in_if  in_bus ();
  sld_out_if out_bus ();

  string_literal_utf8_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte words waiting to be driven, and characters the decoder still owes us.
  byte_word_t pending_words[$];
  char_word_t expected_chars[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_queued;
  int          error_count;
  int          stall_cycles;

  // Local copy of the decoder state, advanced once per accepted word.
  logic [PEND_W-1:0] cont_left;
  logic [CP_W-1:0]   cp_accum;
  logic              esc_armed;
  logic [COL_W-1:0]  char_idx;
  logic [COL_W-1:0]  base_col;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // The column is the literal's start column plus the character index; it
  // pins at the top value instead of wrapping.
  function automatic logic [COL_W-1:0] column_now();
    logic [COL_W:0] sum;
    sum = {1'b0, base_col} + {1'b0, char_idx};
    return sum[COL_W] ? COL_MAX : sum[COL_W-1:0];
  endfunction

  // The character index also saturates, so a very long literal keeps
  // reporting the top column rather than restarting at zero.
  function automatic void advance_index();
    if (char_idx != COL_MAX) char_idx = char_idx + 1'b1;
  endfunction

  function automatic void expect_char(input logic [CP_W-1:0] cp, input logic bad);
    char_word_t c;
    c.code_point = cp;
    c.column     = column_now();
    c.bad_lead   = bad;
    expected_chars.push_back(c);
    advance_index();
  endfunction

  function automatic void decode_word(input byte_word_t w);
    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   cp;
    logic              char_done;
    b         = w.data_byte;
    cp        = '0;
    char_done = 1'b0;
    case (w.action)
      ACT_OPEN: begin
        // A new literal starts from scratch at its own column.
        cont_left = '0;
        cp_accum  = '0;
        esc_armed = 1'b0;
        char_idx  = '0;
        base_col  = w.start_column;
      end
      ACT_CLOSE: begin
        // Half-built characters and a dangling backslash are thrown away, but
        // the index and base column survive.
        cont_left = '0;
        cp_accum  = '0;
        esc_armed = 1'b0;
      end
      ACT_BODY: begin
        if (cont_left != '0) begin
          // Continuation bytes contribute their low six bits, unchecked.
          cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
          cont_left = cont_left - 1'b1;
          if (cont_left == '0) begin
            cp        = cp_accum;
            cp_accum  = '0;
            char_done = 1'b1;
          end
        end else if (!b[7]) begin
          cp        = {{(CP_W-7){1'b0}}, b[6:0]};
          char_done = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          cp_accum  = {{(CP_W-5){1'b0}}, b[4:0]};
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          cp_accum  = {{(CP_W-4){1'b0}}, b[3:0]};
          cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          cp_accum  = {{(CP_W-3){1'b0}}, b[2:0]};
          cont_left = 2'd3;
        end else begin
          // A stray continuation byte or a five-byte-and-up lead is reported
          // as a bad character and wipes the assembly and any escape.
          cp_accum  = '0;
          cont_left = '0;
          esc_armed = 1'b0;
          expect_char('0, 1'b1);
        end
        if (char_done) begin
          if (esc_armed) begin
            esc_armed = 1'b0;
            if (cp == CH_N) cp = CP_LF;
            else if (cp == CH_R) cp = CP_CR;
            else if (cp == CH_E) cp = CP_ESC;
            expect_char(cp, 1'b0);
          end else if (cp == CH_BACKSLASH) begin
            // The backslash itself produces nothing but still takes an index.
            esc_armed = 1'b1;
            advance_index();
          end else begin
            expect_char(cp, 1'b0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic void queue_word(input logic [ACTION_W-1:0] act,
                                     input logic [BYTE_W-1:0] b,
                                     input logic [COL_W-1:0] col);
    byte_word_t w;
    w.action       = act;
    w.data_byte    = b;
    w.start_column = col;
    pending_words.push_back(w);
    if (act != ACT_UNUSED) words_queued++;
  endfunction

  // Body words carry a random column, which the decoder must not look at.
  function automatic void queue_body(input logic [BYTE_W-1:0] b);
    queue_word(ACT_BODY, b, COL_W'($urandom_range(0, 65535)));
  endfunction

  // Continuation bytes are mostly well formed; now and then anything goes,
  // since the decoder is not supposed to check them.
  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Lead byte of an n-byte sequence followed by the given number of
  // continuation bytes; fewer than n-1 leaves the character unfinished.
  function automatic void queue_multibyte(input int unsigned n, input int unsigned conts);
    case (n)
      2:       queue_body({3'b110, 5'($urandom_range(0, 31))});
      3:       queue_body({4'b1110, 4'($urandom_range(0, 15))});
      default: queue_body({5'b11110, 3'($urandom_range(0, 7))});
    endcase
    repeat (conts) queue_body(cont_byte());
  endfunction

  function automatic void queue_bad_lead();
    if ($urandom_range(0, 1) == 0) queue_body({2'b10, 6'($urandom_range(0, 63))});
    else queue_body({5'b11111, 3'($urandom_range(0, 7))});
  endfunction

  function automatic void queue_escape();
    int unsigned n;
    queue_body(BYTE_W'(CH_BACKSLASH));
    case ($urandom_range(0, 5))
      0: queue_body(BYTE_W'(CH_N));
      1: queue_body(BYTE_W'(CH_R));
      2: queue_body(BYTE_W'(CH_E));
      3: queue_body(BYTE_W'(CH_BACKSLASH));
      4: queue_body(BYTE_W'($urandom_range(0, 127)));
      default: begin
        n = $urandom_range(2, 4);
        queue_multibyte(n, n - 1);
      end
    endcase
  endfunction

  function automatic void queue_character();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      queue_body(BYTE_W'($urandom_range(0, 127)));
    end else if (pick < 52) begin
      queue_escape();
    end else if (pick < 88) begin
      n = $urandom_range(2, 4);
      queue_multibyte(n, n - 1);
    end else if (pick < 95) begin
      queue_bad_lead();
    end else begin
      // Truncated sequence: the next bytes are swallowed as continuations.
      n = $urandom_range(2, 4);
      queue_multibyte(n, $urandom_range(0, n - 2));
    end
  endfunction

  function automatic logic [COL_W-1:0] pick_start_column();
    case ($urandom_range(0, 3))
      0:       return COL_W'($urandom_range(65520, 65535));
      1:       return COL_W'($urandom_range(0, 65535));
      default: return COL_W'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] ACT_WORD_RANDOM();
    return ACTION_W'($urandom_range(0, 3));
  endfunction

  // Mostly complete literals with random content; a few are cut short in the
  // middle of a character or never closed, and a few bursts are pure noise.
  function automatic void queue_random_items(input int unsigned count);
    int unsigned first;
    int unsigned pick;
    first = words_queued;
    while (words_queued - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        queue_word(ACT_OPEN, BYTE_W'($urandom_range(0, 255)), pick_start_column());
        repeat ($urandom_range(0, 14)) queue_character();
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          queue_word(ACT_CLOSE, BYTE_W'($urandom_range(0, 255)),
                     COL_W'($urandom_range(0, 65535)));
        end else if (pick < 95) begin
          queue_multibyte($urandom_range(2, 4), 0);
          queue_word(ACT_CLOSE, BYTE_W'($urandom_range(0, 255)),
                     COL_W'($urandom_range(0, 65535)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_word(ACT_WORD_RANDOM(), BYTE_W'($urandom_range(0, 255)),
                     COL_W'($urandom_range(0, 65535)));
        end
      end
    end
  endfunction

  function automatic void queue_directed();
    // Body bytes ahead of any opening delimiter decode against column zero.
    queue_body(8'h41);
    queue_body(8'h00);
    // A literal two columns short of the top: the third character saturates.
    queue_word(ACT_OPEN, 8'hFF, 16'hFFFE);
    queue_body(8'h7F);
    queue_body(BYTE_W'(CH_BACKSLASH));
    queue_body(BYTE_W'(CH_N));
    queue_body(BYTE_W'(CH_BACKSLASH));
    queue_body(BYTE_W'(CH_E));
    queue_body(BYTE_W'(CH_BACKSLASH));
    queue_body(BYTE_W'(CH_BACKSLASH));
    // Invalid leads: a lone continuation byte and an all-ones byte.
    queue_body(8'h80);
    queue_body(8'hFF);
    // Two-byte sign, then the largest four-byte pattern.
    queue_body(8'hC2);
    queue_body(8'hA9);
    queue_body(8'hF7);
    queue_body(8'hBF);
    queue_body(8'hBF);
    queue_body(8'hBF);
    // The meaningless action code must leave everything as it was.
    queue_word(ACT_UNUSED, 8'hFF, 16'hFFFF);
    // A three-byte lead and an armed escape are both dropped by the close.
    queue_body(8'hE2);
    queue_word(ACT_CLOSE, 8'h00, 16'h0000);
    queue_word(ACT_OPEN, 8'h00, 16'h0000);
    queue_body(BYTE_W'(CH_BACKSLASH));
    queue_word(ACT_CLOSE, 8'hFF, 16'hFFFF);
    queue_body(BYTE_W'(CH_R));
  endfunction

  // Holds the sender back until every byte has gone in and every character
  // has come out.
  task automatic drain_all();
    while (pending_words.size() != 0 || in_bus.valid) @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next queued byte word, or idles at random. The word
  // on the bus is handed to the model at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  byte_word_t word_on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) decode_word(word_on_bus);
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          word_on_bus            = pending_words.pop_front();
          in_bus.valid          <= 1'b1;
          in_bus.action         <= word_on_bus.action;
          in_bus.data_byte      <= word_on_bus.data_byte;
          in_bus.start_column   <= word_on_bus.start_column;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and checks every character
  // word taken against the oldest one the model predicted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    char_word_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character word: code_point %0h column %0d bad_lead %0b",
                 out_bus.code_point, out_bus.column, out_bus.bad_lead);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_bus.code_point !== want.code_point) begin
            $error("code_point mismatch: expected %0h, actual %0h",
                   want.code_point, out_bus.code_point);
            error_count++;
          end
          if (out_bus.column !== want.column) begin
            $error("column mismatch: expected %0d, actual %0d", want.column, out_bus.column);
            error_count++;
          end
          if (out_bus.bad_lead !== want.bad_lead) begin
            $error("bad_lead mismatch: expected %0b, actual %0b",
                   want.bad_lead, out_bus.bad_lead);
            error_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence: directed words, then three random phases with different
  // idling on each side, each one drained completely before the next.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.action       = '0;
    in_bus.data_byte    = '0;
    in_bus.start_column = '0;
    out_bus.ready       = 1'b0;
    error_count         = 0;
    stall_cycles        = 0;
    words_queued        = 0;
    cont_left           = '0;
    cp_accum            = '0;
    esc_armed           = 1'b0;
    char_idx            = '0;
    base_col            = '0;
    send_idle_pct       = 11;
    recv_idle_pct       = 56;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed();
    queue_random_items(510);
    drain_all();

    send_idle_pct = 56;
    recv_idle_pct = 11;
    queue_random_items(510);
    drain_all();

    // Back to back on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_items(510);
    drain_all();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
